// File: src/dem_pkg.sv
// Shared widths, codes and types for the disparity error metrics block.
package dem_pkg;

   localparam int TRUTH_W    = 8;
   localparam int EST_W      = 12;
   localparam int TOL_W      = 10;
   localparam int TALLY_W    = 22;
   localparam int SQ_W       = 39;
   localparam int REL_W      = 46;
   localparam int MSE_W      = 25;
   localparam int FRAC_W     = 17;
   localparam int DVD_W      = 47;
   localparam int DIVR_W     = 22;
   localparam int CNT_W      = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int MAX_PIXELS = 2097152;
   localparam int PIX_ITERS   = 24;
   localparam int FRAME_ITERS = DVD_W;

   localparam logic [TOL_W-1:0] TOL_COARSE_RST = 10'd10;
   localparam logic [TOL_W-1:0] TOL_MEDIUM_RST = 10'd20;
   localparam logic [TOL_W-1:0] TOL_FINE_RST   = 10'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOL_COARSE = 2'd0,
      CSR_TOL_MEDIUM = 2'd1,
      CSR_TOL_FINE   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      SEL_PIX    = 3'd0,
      SEL_MSE    = 3'd1,
      SEL_REL    = 3'd2,
      SEL_COARSE = 3'd3,
      SEL_MEDIUM = 3'd4,
      SEL_FINE   = 3'd5
   } div_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PDIV,
      ST_ACC,
      ST_FSTART,
      ST_FDIV,
      ST_FSAVE,
      ST_FDONE
   } state_type;

   typedef struct packed {
      logic        load_in;
      logic        div_load;
      div_sel_type div_sel;
      logic        div_step;
      logic        acc;
      logic        save;
      logic        out_load;
      logic        clear;
   } cmd_type;

   typedef struct packed {
      logic pix_ok;
      logic last;
      logic n_zero;
      logic out_busy;
   } stat_type;

endpackage

// File: src/dem_datapath.sv
// Datapath: input latch, per-pixel terms, accumulators, shared divider, result registers.
module dem_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [dem_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dem_pkg::TOL_W-1:0]         csr_wdata,
   input  logic [dem_pkg::TRUTH_W-1:0]       req_truth_disp,
   input  logic [dem_pkg::EST_W-1:0]         req_est_disp_q4,
   input  logic                              req_frame_end,
   input  dem_pkg::cmd_type                  cmd,
   output dem_pkg::stat_type                 stat,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [dem_pkg::MSE_W-1:0]         rsp_mse_q8,
   output logic [dem_pkg::MSE_W-1:0]         rsp_rel_err_q16,
   output logic [dem_pkg::FRAC_W-1:0]        rsp_frac_coarse_q16,
   output logic [dem_pkg::FRAC_W-1:0]        rsp_frac_medium_q16,
   output logic [dem_pkg::FRAC_W-1:0]        rsp_frac_fine_q16,
   output logic [dem_pkg::TALLY_W-1:0]       rsp_valid_pixels,
   output logic                              rsp_none_valid
);

   logic [dem_pkg::TOL_W-1:0]   tol_coarse_ff, tol_medium_ff, tol_fine_ff;
   logic [dem_pkg::TRUTH_W-1:0] truth_ff;
   logic [dem_pkg::EST_W-1:0]   est_ff;
   logic                        last_ff;

   logic [dem_pkg::TALLY_W-1:0] tally_ff, coarse_ff, medium_ff, fine_ff;
   logic [dem_pkg::SQ_W-1:0]    sq_sum_ff;
   logic [dem_pkg::REL_W-1:0]   rel_sum_ff;

   logic [dem_pkg::DVD_W-1:0]   dvd_ff, dvd_in;
   logic [dem_pkg::DVD_W-1:0]   quo_ff, quo_in;
   logic [dem_pkg::DIVR_W-1:0]  rem_ff, rem_in;
   logic [dem_pkg::DIVR_W-1:0]  divisor_ff, divisor_in;

   logic [dem_pkg::MSE_W-1:0]   mse_res_ff, rel_res_ff;
   logic [dem_pkg::FRAC_W-1:0]  fc_res_ff, fm_res_ff, ff_res_ff;
   logic                        rsp_valid_ff;

   logic [dem_pkg::EST_W:0]     est_sum;
   logic [8:0]                  est_int, truth9, diff9;
   logic [7:0]                  diff;
   logic [15:0]                 sq;
   logic [17:0]                 prod_c, prod_m, prod_f;
   logic                        hit_c, hit_m, hit_f;
   logic [dem_pkg::DIVR_W:0]    trial, trial_sub;
   logic                        trial_ge;
   logic [dem_pkg::TALLY_W-1:0] frac_tally;

   // per-pixel terms from the latched pair
   always_comb begin
      est_sum = {1'b0, est_ff} + 13'd8;
      est_int = est_sum[12:4];
      truth9  = {1'b0, truth_ff};
      diff9   = (truth9 > est_int) ? (truth9 - est_int) : (est_int - truth9);
      diff    = diff9[7:0];
      sq      = diff * diff;
      prod_c  = diff * tol_coarse_ff;
      prod_m  = diff * tol_medium_ff;
      prod_f  = diff * tol_fine_ff;
      hit_c   = prod_c < {10'd0, truth_ff};
      hit_m   = prod_m < {10'd0, truth_ff};
      hit_f   = prod_f < {10'd0, truth_ff};
   end

   assign stat.pix_ok = (truth_ff != '0) && (est_int != '0)
                        && (tally_ff < dem_pkg::TALLY_W'(dem_pkg::MAX_PIXELS));
   assign stat.last     = last_ff;
   assign stat.n_zero   = (tally_ff == '0);
   assign stat.out_busy = rsp_valid_ff && rsp_stall;

   // divider load and restoring step
   always_comb begin
      case (cmd.div_sel)
         dem_pkg::SEL_COARSE: frac_tally = coarse_ff;
         dem_pkg::SEL_MEDIUM: frac_tally = medium_ff;
         default:             frac_tally = fine_ff;
      endcase

      trial     = {rem_ff, dvd_ff[dem_pkg::DVD_W-1]};
      trial_sub = trial - {1'b0, divisor_ff};
      trial_ge  = trial >= {1'b0, divisor_ff};

      dvd_in     = {dvd_ff[dem_pkg::DVD_W-2:0], 1'b0};
      quo_in     = {quo_ff[dem_pkg::DVD_W-2:0], trial_ge};
      rem_in     = trial_ge ? trial_sub[dem_pkg::DIVR_W-1:0] : trial[dem_pkg::DIVR_W-1:0];
      divisor_in = divisor_ff;

      if (cmd.div_load) begin
         quo_in = '0;
         rem_in = '0;
         case (cmd.div_sel)
            dem_pkg::SEL_PIX: begin
               dvd_in     = {diff, 39'd0};
               divisor_in = {14'd0, truth_ff};
            end
            dem_pkg::SEL_MSE: begin
               dvd_in     = {sq_sum_ff, 8'd0};
               divisor_in = tally_ff;
            end
            dem_pkg::SEL_REL: begin
               dvd_in     = {1'b0, rel_sum_ff};
               divisor_in = tally_ff;
            end
            default: begin
               dvd_in     = {9'd0, frac_tally, 16'd0};
               divisor_in = tally_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         truth_ff <= req_truth_disp;
         est_ff   <= req_est_disp_q4;
         last_ff  <= req_frame_end;
      end
      if (cmd.div_load || cmd.div_step) begin
         dvd_ff     <= dvd_in;
         quo_ff     <= quo_in;
         rem_ff     <= rem_in;
         divisor_ff <= divisor_in;
      end
      if (cmd.save) begin
         case (cmd.div_sel)
            dem_pkg::SEL_MSE:    mse_res_ff <= quo_ff[dem_pkg::MSE_W-1:0];
            dem_pkg::SEL_REL:    rel_res_ff <= quo_ff[dem_pkg::MSE_W-1:0];
            dem_pkg::SEL_COARSE: fc_res_ff  <= quo_ff[dem_pkg::FRAC_W-1:0];
            dem_pkg::SEL_MEDIUM: fm_res_ff  <= quo_ff[dem_pkg::FRAC_W-1:0];
            dem_pkg::SEL_FINE:   ff_res_ff  <= quo_ff[dem_pkg::FRAC_W-1:0];
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         if (tally_ff == '0) begin
            rsp_mse_q8          <= '0;
            rsp_rel_err_q16     <= '0;
            rsp_frac_coarse_q16 <= '0;
            rsp_frac_medium_q16 <= '0;
            rsp_frac_fine_q16   <= '0;
            rsp_none_valid      <= 1'b1;
         end else begin
            rsp_mse_q8          <= mse_res_ff;
            rsp_rel_err_q16     <= rel_res_ff;
            rsp_frac_coarse_q16 <= fc_res_ff;
            rsp_frac_medium_q16 <= fm_res_ff;
            rsp_frac_fine_q16   <= ff_res_ff;
            rsp_none_valid      <= 1'b0;
         end
         rsp_valid_pixels <= tally_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_coarse_ff <= dem_pkg::TOL_COARSE_RST;
         tol_medium_ff <= dem_pkg::TOL_MEDIUM_RST;
         tol_fine_ff   <= dem_pkg::TOL_FINE_RST;
         tally_ff      <= '0;
         coarse_ff     <= '0;
         medium_ff     <= '0;
         fine_ff       <= '0;
         sq_sum_ff     <= '0;
         rel_sum_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               dem_pkg::CSR_TOL_COARSE: tol_coarse_ff <= csr_wdata;
               dem_pkg::CSR_TOL_MEDIUM: tol_medium_ff <= csr_wdata;
               dem_pkg::CSR_TOL_FINE:   tol_fine_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.clear) begin
            tally_ff   <= '0;
            coarse_ff  <= '0;
            medium_ff  <= '0;
            fine_ff    <= '0;
            sq_sum_ff  <= '0;
            rel_sum_ff <= '0;
         end else if (cmd.acc) begin
            tally_ff   <= tally_ff + 1'b1;
            coarse_ff  <= coarse_ff + dem_pkg::TALLY_W'(hit_c);
            medium_ff  <= medium_ff + dem_pkg::TALLY_W'(hit_m);
            fine_ff    <= fine_ff + dem_pkg::TALLY_W'(hit_f);
            sq_sum_ff  <= sq_sum_ff + dem_pkg::SQ_W'(sq);
            rel_sum_ff <= rel_sum_ff + dem_pkg::REL_W'(quo_ff[23:0]);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while held");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> divisor_ff != '0)
      else $error("divide step with zero divisor");

   a_tally_bound: assert property (@(posedge clock) disable iff (reset)
      tally_ff <= dem_pkg::TALLY_W'(dem_pkg::MAX_PIXELS))
      else $error("pixel tally above limit");

   a_acc_after_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> tally_ff == '0 && sq_sum_ff == '0)
      else $error("accumulators not cleared");

endmodule

// File: src/dem_ctrl.sv
// Controller: sequences input transfer, pixel divide, accumulate and frame divides.
module dem_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dem_pkg::stat_type  stat,
   output dem_pkg::cmd_type   cmd
);

   dem_pkg::state_type         state_ff, state_in;
   dem_pkg::div_sel_type       sel_ff, sel_in;
   logic [dem_pkg::CNT_W-1:0]  cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dem_pkg::ST_IDLE;
         sel_ff   <= dem_pkg::SEL_PIX;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cnt_in    = cnt_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.div_sel = sel_ff;

      case (state_ff)
         dem_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = dem_pkg::ST_EVAL;
            end
         end
         dem_pkg::ST_EVAL: begin
            if (stat.pix_ok) begin
               cmd.div_load = 1'b1;
               cmd.div_sel  = dem_pkg::SEL_PIX;
               cnt_in       = dem_pkg::CNT_W'(dem_pkg::PIX_ITERS - 1);
               state_in     = dem_pkg::ST_PDIV;
            end else if (stat.last) begin
               sel_in   = dem_pkg::SEL_MSE;
               state_in = dem_pkg::ST_FSTART;
            end else begin
               state_in = dem_pkg::ST_IDLE;
            end
         end
         dem_pkg::ST_PDIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = dem_pkg::ST_ACC;
            end
         end
         dem_pkg::ST_ACC: begin
            cmd.acc = 1'b1;
            if (stat.last) begin
               sel_in   = dem_pkg::SEL_MSE;
               state_in = dem_pkg::ST_FSTART;
            end else begin
               state_in = dem_pkg::ST_IDLE;
            end
         end
         dem_pkg::ST_FSTART: begin
            if (stat.n_zero) begin
               state_in = dem_pkg::ST_FDONE;
            end else begin
               cmd.div_load = 1'b1;
               cnt_in       = dem_pkg::CNT_W'(dem_pkg::FRAME_ITERS - 1);
               state_in     = dem_pkg::ST_FDIV;
            end
         end
         dem_pkg::ST_FDIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = dem_pkg::ST_FSAVE;
            end
         end
         dem_pkg::ST_FSAVE: begin
            cmd.save = 1'b1;
            if (sel_ff == dem_pkg::SEL_FINE) begin
               state_in = dem_pkg::ST_FDONE;
            end else begin
               sel_in   = dem_pkg::div_sel_type'(sel_ff + 3'd1);
               state_in = dem_pkg::ST_FSTART;
            end
         end
         dem_pkg::ST_FDONE: begin
            // hold until the output register is free
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = dem_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dem_pkg::ST_IDLE;
         end
      endcase
   end

   a_frame_sel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dem_pkg::ST_FDIV) |-> (sel_ff != dem_pkg::SEL_PIX))
      else $error("frame divide with pixel operand select");

   a_pdiv_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dem_pkg::ST_PDIV) |-> cnt_ff < dem_pkg::CNT_W'(dem_pkg::PIX_ITERS))
      else $error("pixel divide count out of range");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_in |=> state_ff == dem_pkg::ST_EVAL)
      else $error("transfer not followed by evaluation");

endmodule

// File: src/disparity_error_metrics_top.sv
// Top level of the stereo disparity error metrics block.
//
// Input channel req_*: one pixel pair per transfer (truth disparity, Q8.4
// estimate, frame_end marking the last pixel of an image). Result channel
// rsp_*: one metrics record per image, sent after the frame_end pixel.
// csr_*: write-only tolerance factors, index 0 coarse, 1 medium, 2 fine.
// One pixel is processed at a time; no new pixel is taken until the last
// one is through. A skipped pixel (either value zero or the pixel limit
// reached) needs no divide; a counted pixel runs the 24 steps of the
// bit-serial divider for the relative error. A frame_end pixel adds five
// 47-step divides of the accumulators by the pixel count on the same
// divider, then an output register load. An empty image skips the divides.
// The result stays in its register while rsp_stall is high; pixels of the
// next image are still taken meanwhile, and only the next image's result
// waits for that register to free up.
// Synchronous reset restores the default factors (10, 20, 100), clears the
// accumulators and drops rsp_valid.
module disparity_error_metrics_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [dem_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dem_pkg::TOL_W-1:0]      csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dem_pkg::TRUTH_W-1:0]    req_truth_disp,
   input  logic [dem_pkg::EST_W-1:0]      req_est_disp_q4,
   input  logic                           req_frame_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dem_pkg::MSE_W-1:0]      rsp_mse_q8,
   output logic [dem_pkg::MSE_W-1:0]      rsp_rel_err_q16,
   output logic [dem_pkg::FRAC_W-1:0]     rsp_frac_coarse_q16,
   output logic [dem_pkg::FRAC_W-1:0]     rsp_frac_medium_q16,
   output logic [dem_pkg::FRAC_W-1:0]     rsp_frac_fine_q16,
   output logic [dem_pkg::TALLY_W-1:0]    rsp_valid_pixels,
   output logic                           rsp_none_valid
);

   dem_pkg::cmd_type  cmd;
   dem_pkg::stat_type stat;

   dem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dem_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_truth_disp      (req_truth_disp),
      .req_est_disp_q4     (req_est_disp_q4),
      .req_frame_end       (req_frame_end),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_mse_q8          (rsp_mse_q8),
      .rsp_rel_err_q16     (rsp_rel_err_q16),
      .rsp_frac_coarse_q16 (rsp_frac_coarse_q16),
      .rsp_frac_medium_q16 (rsp_frac_medium_q16),
      .rsp_frac_fine_q16   (rsp_frac_fine_q16),
      .rsp_valid_pixels    (rsp_valid_pixels),
      .rsp_none_valid      (rsp_none_valid)
   );

endmodule
